### sv/jtok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer package
// Shared constants, event and stack frame types, and small decode functions.
// ----------------------------------------------------------------------------
package jtok_pkg;

    localparam int STACK_DEPTH     = 16;
    localparam int LVL_W           = $clog2(STACK_DEPTH);
    localparam int NUMBER_TEXT_MAX = 32;
    localparam int NUM_W           = $clog2(NUMBER_TEXT_MAX + 1);
    localparam int INDEX_WIDTH     = 16;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
    localparam int CNT_W           = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_OBJ   = 3'd1;
    localparam logic [2:0] K_ARR   = 3'd2;
    localparam logic [2:0] K_STR   = 3'd3;
    localparam logic [2:0] K_NUM   = 3'd4;
    localparam logic [2:0] K_TRUE  = 3'd5;
    localparam logic [2:0] K_FALSE = 3'd6;
    localparam logic [2:0] K_NULL  = 3'd7;

    localparam logic [2:0] VT_OBJECT = 3'd0;
    localparam logic [2:0] VT_ARRAY  = 3'd1;
    localparam logic [2:0] VT_STRING = 3'd2;
    localparam logic [2:0] VT_NUMBER = 3'd3;
    localparam logic [2:0] VT_ERROR  = 3'd7;

    localparam logic [7:0] F_KEY   = 8'h08;
    localparam logic [7:0] F_COMMA = 8'h10;
    localparam logic [7:0] F_COLON = 8'h20;
    localparam logic [7:0] F_START = 8'h40;

    typedef struct packed {
        logic [2:0]  value_type;
        logic        is_start;
        logic        is_end;
        logic        is_key;
        logic [3:0]  nest_level;
        logic [15:0] element_index;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last;
    } t_evt;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] idx;
        logic [2:0]             par_kind;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);

    function automatic t_evt mk_evt(input logic [2:0] vt, input logic st, input logic en,
                                    input logic key, input logic [LVL_W-1:0] lvl,
                                    input logic [INDEX_WIDTH-1:0] idx,
                                    input logic [7:0] data, input logic dv);
        t_evt e;
        e.value_type    = vt;
        e.is_start      = st;
        e.is_end        = en;
        e.is_key        = key;
        e.nest_level    = 4'(lvl);
        e.element_index = 16'(idx);
        e.data_byte     = data;
        e.data_valid    = dv;
        e.last          = 1'b0;
        return e;
    endfunction

    function automatic t_evt err_evt();
        t_evt e;
        e            = '0;
        e.value_type = VT_ERROR;
        e.last       = 1'b1;
        return e;
    endfunction

    function automatic logic [INDEX_WIDTH-1:0] sat_inc(input logic [INDEX_WIDTH-1:0] v);
        return (&v) ? v : v + INDEX_WIDTH'(1);
    endfunction

    // Bit 4 flags a valid hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
        else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
        else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
        return r;
    endfunction

    function automatic logic is_num_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || b == "." || b == "+" || b == "-" ||
               b == "E" || b == "e";
    endfunction

    function automatic logic [2:0] lit_len(input logic [2:0] kind);
        return (kind == K_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [2:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            K_TRUE: begin
                case (pos)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            K_FALSE: begin
                case (pos)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/jtok_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer input channel
// Valid/ready channel carrying one text byte per beat.
// ----------------------------------------------------------------------------
interface jtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

### sv/jtok_evt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer event channel
// Valid/ready channel carrying one tokenizer event per beat.
// ----------------------------------------------------------------------------
interface jtok_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  value_type;
    logic        is_start;
    logic        is_end;
    logic        is_key;
    logic [3:0]  nest_level;
    logic [15:0] element_index;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;

    modport source (output valid, output value_type, output is_start, output is_end,
                    output is_key, output nest_level, output element_index,
                    output data_byte, output data_valid, output last, input ready);
    modport sink (input valid, input value_type, input is_start, input is_end,
                  input is_key, input nest_level, input element_index,
                  input data_byte, input data_valid, input last, output ready);
endinterface
`default_nettype wire

### sv/jtok_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jtok_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/streaming_json_tokenizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Streaming JSON tokenizer
// Turns a JSON byte stream into object, array, string, number and literal
// events, with escape decoding and UTF-8 checks inside strings.
// ----------------------------------------------------------------------------
// Events are written into a registered event buffer when their byte is accepted.
// A byte is taken every cycle unless input stalls: a closing bracket stalls it while
// the enclosing frame is read back from the stack RAM, and its end event is written
// during that read-back. Bytes also stall while fewer than three buffer slots are
// free, as a byte can cause three events; at most one event leaves per cycle.
// Reset clears the control registers; stack RAM entries are always written by an
// opening bracket before a closing bracket reads them, so the RAM is not cleared.
module streaming_json_tokenizer_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    jtok_in_if.sink  i_in,
    jtok_evt_if.source o_evt
);
    import jtok_pkg::*;

    logic [7:0]             r_flags, n_flags;
    logic [INDEX_WIDTH-1:0] r_idx, n_idx;
    logic [2:0]             r_par, n_par;
    logic [LVL_W-1:0]       r_level, n_level;
    logic [2:0]             r_pend, n_pend;
    logic [1:0]             r_utf, n_utf;
    logic [15:0]            r_hex, n_hex;
    logic [NUM_W-1:0]       r_numlen, n_numlen;
    logic                   r_err, n_err;
    logic                   r_fill, n_fill;
    logic [2:0]             r_fill_vt, n_fill_vt;

    t_evt                   r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]       r_cnt;

    t_evt                   ev [3];
    logic [1:0]             ne;
    logic                   err_hit, do_n, push, pop;
    logic [7:0]             b, fe, sb;
    logic [INDEX_WIDTH-1:0] ie;
    logic [2:0]             kind, want;
    logic [4:0]             hv;
    logic [15:0]            hx;
    logic                   in_acc, out_acc, empty_ok;
    t_frame                 wdata, rdata;

    assign b       = i_in.in_byte;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_evt.valid && o_evt.ready;
    assign i_in.ready = !r_fill && (r_cnt <= CNT_W'(FIFO_DEPTH - 3));
    assign kind    = r_flags[2:0];
    assign hv      = hex_val(b);
    assign wdata   = '{idx: ie, par_kind: r_par};

    jtok_ram #(.W(FRAME_W), .D(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_level),
        .i_wdata (wdata),
        .i_raddr (r_level - LVL_W'(1)),
        .o_rdata (rdata)
    );

    always_comb begin
        n_flags   = r_flags;
        n_idx     = r_idx;
        n_par     = r_par;
        n_level   = r_level;
        n_pend    = r_pend;
        n_utf     = r_utf;
        n_hex     = r_hex;
        n_numlen  = r_numlen;
        n_err     = r_err;
        n_fill    = 1'b0;
        n_fill_vt = r_fill_vt;
        ev[0]     = '0;
        ev[1]     = '0;
        ev[2]     = '0;
        ne        = 2'd0;
        err_hit   = 1'b0;
        do_n      = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        fe        = r_flags;
        ie        = r_idx;
        want      = K_OBJ;
        empty_ok  = 1'b0;
        hx        = {r_hex[11:0], hv[3:0]};
        sb        = b;
        if (r_fill) begin
            ev[0]   = mk_evt(r_fill_vt, 1'b0, 1'b1, 1'b0, r_level, rdata.idx, 8'h00, 1'b0);
            ne      = 2'd1;
            n_flags = F_COMMA;
            n_idx   = sat_inc(rdata.idx);
            n_par   = rdata.par_kind;
        end else if (in_acc && !r_err) begin
            if (kind == K_STR) begin
                if (r_utf != 2'd0) begin
                    if (b[7:6] != 2'b10) begin
                        err_hit = 1'b1;
                    end else begin
                        ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3], r_level,
                                       r_idx, b, 1'b1);
                        ne      = 2'd1;
                        n_flags = r_flags & ~F_START;
                        n_utf   = r_utf - 2'd1;
                    end
                end else if (r_pend == 3'd0) begin
                    if (b == "\\") begin
                        n_pend = 3'd1;
                    end else if (b == "\"") begin
                        ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b1, r_flags[3], r_level,
                                       r_idx, 8'h00, 1'b0);
                        ne = 2'd1;
                        if (r_flags[3]) begin
                            n_flags = F_COLON;
                        end else begin
                            n_flags = F_COMMA;
                            n_idx   = sat_inc(r_idx);
                        end
                    end else begin
                        if (b[7] == 1'b0) n_utf = 2'd0;
                        else if (b[7:5] == 3'b110) n_utf = 2'd1;
                        else if (b[7:4] == 4'b1110) n_utf = 2'd2;
                        else if (b[7:3] == 5'b11110) n_utf = 2'd3;
                        else err_hit = 1'b1;
                        if (!err_hit) begin
                            ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3], r_level,
                                           r_idx, b, 1'b1);
                            ne      = 2'd1;
                            n_flags = r_flags & ~F_START;
                        end
                    end
                end else if (r_pend == 3'd1) begin
                    case (b)
                        "\"", "\\", "/": sb = b;
                        "b": sb = 8'h08;
                        "f": sb = 8'h0C;
                        "n": sb = 8'h0A;
                        "r": sb = 8'h0D;
                        "t": sb = 8'h09;
                        "u": sb = 8'h00;
                        default: err_hit = 1'b1;
                    endcase
                    if (b == "u") begin
                        n_pend = 3'd2;
                        n_hex  = 16'h0000;
                    end else if (!err_hit) begin
                        n_pend = 3'd0;
                        ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3], r_level,
                                       r_idx, sb, 1'b1);
                        ne      = 2'd1;
                        n_flags = r_flags & ~F_START;
                    end
                end else begin
                    if (!hv[4]) begin
                        err_hit = 1'b1;
                    end else begin
                        n_hex = hx;
                        if (r_pend < 3'd5) begin
                            n_pend = r_pend + 3'd1;
                        end else begin
                            n_pend  = 3'd0;
                            n_flags = r_flags & ~F_START;
                            if (hx < 16'd128) begin
                                ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3],
                                               r_level, r_idx, hx[7:0], 1'b1);
                                ne = 2'd1;
                            end else if (hx < 16'd2048) begin
                                ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3],
                                               r_level, r_idx, {3'b110, hx[10:6]}, 1'b1);
                                ev[1] = mk_evt(VT_STRING, 1'b0, 1'b0, r_flags[3],
                                               r_level, r_idx, {2'b10, hx[5:0]}, 1'b1);
                                ne = 2'd2;
                            end else begin
                                ev[0] = mk_evt(VT_STRING, r_flags[6], 1'b0, r_flags[3],
                                               r_level, r_idx, {4'b1110, hx[15:12]}, 1'b1);
                                ev[1] = mk_evt(VT_STRING, 1'b0, 1'b0, r_flags[3],
                                               r_level, r_idx, {2'b10, hx[11:6]}, 1'b1);
                                ev[2] = mk_evt(VT_STRING, 1'b0, 1'b0, r_flags[3],
                                               r_level, r_idx, {2'b10, hx[5:0]}, 1'b1);
                                ne = 2'd3;
                            end
                        end
                    end
                end
            end else if (kind == K_NUM) begin
                if (is_num_char(b)) begin
                    if (r_numlen >= NUM_W'(NUMBER_TEXT_MAX)) begin
                        err_hit = 1'b1;
                    end else begin
                        ev[0] = mk_evt(VT_NUMBER, 1'b0, 1'b0, 1'b0, r_level, r_idx, b, 1'b1);
                        ne       = 2'd1;
                        n_numlen = r_numlen + NUM_W'(1);
                    end
                end else begin
                    ev[0] = mk_evt(VT_NUMBER, 1'b0, 1'b1, 1'b0, r_level, r_idx, 8'h00, 1'b0);
                    ne       = 2'd1;
                    fe       = F_COMMA;
                    ie       = sat_inc(r_idx);
                    n_flags  = fe;
                    n_idx    = ie;
                    n_numlen = '0;
                    do_n     = 1'b1;
                end
            end else if (kind >= K_TRUE) begin
                if (r_pend >= lit_len(kind) || b != lit_char(kind, r_pend)) begin
                    err_hit = 1'b1;
                end else if (r_pend + 3'd1 == lit_len(kind)) begin
                    n_pend  = 3'd0;
                    ev[0]   = mk_evt(kind - 3'd1, 1'b1, 1'b1, 1'b0, r_level, r_idx,
                                     8'h00, 1'b0);
                    ne      = 2'd1;
                    n_flags = F_COMMA;
                    n_idx   = sat_inc(r_idx);
                end else begin
                    n_pend = r_pend + 3'd1;
                end
            end else begin
                do_n = 1'b1;
            end

            if (do_n) begin
                want = (b == "}") ? K_OBJ : K_ARR;
                if (want == K_OBJ) empty_ok = (ie == '0) && (fe == F_KEY);
                else empty_ok = (ie == '0) && (fe == 8'h00);
                if (b == " " || b == 8'h0A || b == 8'h0D || b == 8'h09) begin
                    n_flags = fe;
                end else if (b == ",") begin
                    if (!fe[4]) err_hit = 1'b1;
                    else if (r_level != '0 && r_par == K_OBJ) n_flags = F_KEY;
                    else n_flags = 8'h00;
                end else if (b == ":") begin
                    if (!fe[5]) err_hit = 1'b1;
                    else n_flags = 8'h00;
                end else if (r_level != '0 && (b == "}" || b == "]")) begin
                    if (r_par != want || (!fe[4] && !empty_ok)) begin
                        err_hit = 1'b1;
                    end else begin
                        pop       = 1'b1;
                        n_level   = r_level - LVL_W'(1);
                        n_fill    = 1'b1;
                        n_fill_vt = want - 3'd1;
                    end
                end else if (r_level != '0 && fe[4]) begin
                    err_hit = 1'b1;
                end else if (!fe[3] && (b == "{" || b == "[")) begin
                    if (r_level == LVL_W'(STACK_DEPTH - 1)) begin
                        err_hit = 1'b1;
                    end else begin
                        ev[ne]  = mk_evt((b == "{") ? VT_OBJECT : VT_ARRAY, 1'b1, 1'b0, 1'b0,
                                         r_level, ie, 8'h00, 1'b0);
                        ne      = ne + 2'd1;
                        push    = 1'b1;
                        n_level = r_level + LVL_W'(1);
                        n_flags = (b == "{") ? F_KEY : 8'h00;
                        n_idx   = '0;
                        n_par   = (b == "{") ? K_OBJ : K_ARR;
                    end
                end else if (b == "\"") begin
                    n_flags = (fe & F_KEY) | {5'b0, K_STR} | F_START;
                    n_pend  = 3'd0;
                    n_utf   = 2'd0;
                end else if (fe[3]) begin
                    err_hit = 1'b1;
                end else if (b == "-" || (b >= "0" && b <= "9")) begin
                    n_flags  = {5'b0, K_NUM};
                    ev[ne]   = mk_evt(VT_NUMBER, 1'b1, 1'b0, 1'b0, r_level, ie, b, 1'b1);
                    ne       = ne + 2'd1;
                    n_numlen = NUM_W'(1);
                end else if (b == "t" || b == "f" || b == "n") begin
                    n_flags = {5'b0, (b == "t") ? K_TRUE : (b == "f") ? K_FALSE : K_NULL};
                    n_pend  = 3'd1;
                end else begin
                    err_hit = 1'b1;
                end
            end

            if (err_hit) begin
                ev[ne] = err_evt();
                ne     = ne + 2'd1;
                n_err  = 1'b1;
            end
        end
        if (ne != 2'd0 && !pop) begin
            ev[ne - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_idx     <= '0;
            r_par     <= K_NONE;
            r_level   <= '0;
            r_pend    <= '0;
            r_utf     <= '0;
            r_hex     <= '0;
            r_numlen  <= '0;
            r_err     <= 1'b0;
            r_fill    <= 1'b0;
            r_fill_vt <= '0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_cnt     <= '0;
        end else begin
            r_flags   <= n_flags;
            r_idx     <= n_idx;
            r_par     <= n_par;
            r_level   <= n_level;
            r_pend    <= n_pend;
            r_utf     <= n_utf;
            r_hex     <= n_hex;
            r_numlen  <= n_numlen;
            r_err     <= n_err;
            r_fill    <= n_fill;
            r_fill_vt <= n_fill_vt;
            r_wr      <= r_wr + FIFO_AW'(ne);
            r_rd      <= r_rd + FIFO_AW'(out_acc);
            r_cnt     <= r_cnt + CNT_W'(ne) - CNT_W'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < ne) begin
                r_fifo[r_wr + FIFO_AW'(k)] <= ev[k];
            end
        end
    end

    assign o_evt.valid         = (r_cnt != '0);
    assign o_evt.value_type    = r_fifo[r_rd].value_type;
    assign o_evt.is_start      = r_fifo[r_rd].is_start;
    assign o_evt.is_end        = r_fifo[r_rd].is_end;
    assign o_evt.is_key        = r_fifo[r_rd].is_key;
    assign o_evt.nest_level    = r_fifo[r_rd].nest_level;
    assign o_evt.element_index = r_fifo[r_rd].element_index;
    assign o_evt.data_byte     = r_fifo[r_rd].data_byte;
    assign o_evt.data_valid    = r_fifo[r_rd].data_valid;
    assign o_evt.last          = r_fifo[r_rd].last;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("event buffer overflow");

    a_fill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill |=> !r_fill)
        else $error("stack read-back lasted more than one cycle");

    a_fill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_fill && (r_level == $past(r_level) - LVL_W'(1)))
        else $error("closing bracket did not start a stack read-back");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (ne == 2'd0) && !push)
        else $error("events produced after an error");
endmodule
`default_nettype wire

### tb/tb_jtok_checker.sv
// ----------------------------------------------------------------------------
// JSON tokenizer event checker
// Watches the byte and event channels, predicts the events that each accepted
// byte must cause from its own model of the nesting stack, and compares every
// event beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_jtok_checker
    import jtok_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jtok_in_if        i_in,
    jtok_evt_if       i_evt,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_event_count
);

    localparam logic [2:0] VT_TRUE  = 3'd4;
    localparam logic [2:0] VT_FALSE = 3'd5;
    localparam logic [2:0] VT_NULL  = 3'd6;

    logic [7:0]  frame_flags [STACK_DEPTH];
    logic [15:0] frame_count [STACK_DEPTH];
    int          depth;
    logic [15:0] hex_acc;
    int          esc_pos;
    int          utf8_left;
    int          num_len;
    bit          stuck;

    t_evt byte_events[$];
    t_evt expected_events[$];

    function automatic void clear_tokenizer();
        for (int i = 0; i < STACK_DEPTH; i++) begin
            frame_flags[i] = '0;
            frame_count[i] = '0;
        end
        depth     = 0;
        hex_acc   = '0;
        esc_pos   = 0;
        utf8_left = 0;
        num_len   = 0;
        stuck     = 1'b0;
    endfunction

    function automatic void add_event(logic [2:0] vt, bit st, bit en, bit key,
                                      logic [7:0] data, bit dv);
        t_evt e;
        if (byte_events.size() >= 3) return;
        e               = '0;
        e.value_type    = vt;
        e.is_start      = st;
        e.is_end        = en;
        e.is_key        = key;
        e.nest_level    = 4'(depth);
        e.element_index = frame_count[depth];
        e.data_byte     = data;
        e.data_valid    = dv;
        byte_events.push_back(e);
    endfunction

    function automatic void add_error();
        t_evt e;
        stuck = 1'b1;
        while (byte_events.size() > 2) void'(byte_events.pop_back());
        e            = '0;
        e.value_type = VT_ERROR;
        byte_events.push_back(e);
    endfunction

    function automatic void add_text(logic [7:0] c);
        logic [7:0] f;
        f = frame_flags[depth];
        add_event(VT_STRING, f[6], 1'b0, f[3], c, 1'b1);
        frame_flags[depth] = f & ~F_START;
    endfunction

    function automatic void close_value();
        if (frame_count[depth] != 16'hFFFF) frame_count[depth]++;
        frame_flags[depth] = F_COMMA;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic bit number_char(logic [7:0] b);
        return (b >= "0" && b <= "9") || b == "." || b == "+" || b == "-" ||
               b == "E" || b == "e";
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        logic [7:0] f;
        logic [2:0] want;
        logic [2:0] kind;
        bit         empty_ok;
        f = frame_flags[depth];
        if (b == " " || b == 8'h0A || b == 8'h0D || b == 8'h09) return;
        if (b == ",") begin
            if (!f[4]) begin
                add_error();
                return;
            end
            if (depth > 0 && frame_flags[depth-1][2:0] == K_OBJ) frame_flags[depth] = F_KEY;
            else frame_flags[depth] = '0;
            return;
        end
        if (b == ":") begin
            if (!f[5]) begin
                add_error();
                return;
            end
            frame_flags[depth] = '0;
            return;
        end
        if (depth > 0 && (b == "}" || b == "]")) begin
            want = (b == "}") ? K_OBJ : K_ARR;
            if (frame_flags[depth-1][2:0] != want) begin
                add_error();
                return;
            end
            empty_ok = frame_count[depth] == 0 && f == ((want == K_OBJ) ? F_KEY : 8'h00);
            if (!f[4] && !empty_ok) begin
                add_error();
                return;
            end
            depth--;
            add_event(want - 3'd1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            close_value();
            return;
        end
        if (depth > 0 && f[4]) begin
            add_error();
            return;
        end
        if (!f[3] && (b == "{" || b == "[")) begin
            if (depth >= STACK_DEPTH - 1) begin
                add_error();
                return;
            end
            kind = (b == "{") ? K_OBJ : K_ARR;
            add_event(kind - 3'd1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
            frame_flags[depth] = 8'(kind);
            depth++;
            frame_count[depth] = '0;
            frame_flags[depth] = (kind == K_OBJ) ? F_KEY : 8'h00;
            return;
        end
        if (b == "\"") begin
            frame_flags[depth] = (f & F_KEY) | 8'(K_STR) | F_START;
            esc_pos   = 0;
            utf8_left = 0;
            return;
        end
        if (f[3]) begin
            add_error();
            return;
        end
        if (b == "-" || (b >= "0" && b <= "9")) begin
            frame_flags[depth] = 8'(K_NUM);
            add_event(VT_NUMBER, 1'b1, 1'b0, 1'b0, b, 1'b1);
            num_len = 1;
            return;
        end
        if (b == "t" || b == "f" || b == "n") begin
            frame_flags[depth] = 8'((b == "t") ? K_TRUE : (b == "f") ? K_FALSE : K_NULL);
            esc_pos = 1;
            return;
        end
        add_error();
    endfunction

    function automatic void string_byte(logic [7:0] b);
        logic [7:0] f;
        logic [7:0] c;
        int         h;
        if (utf8_left > 0) begin
            if ((b & 8'hC0) != 8'h80) begin
                add_error();
                return;
            end
            add_text(b);
            utf8_left--;
            return;
        end
        if (esc_pos == 0) begin
            if (b == "\\") begin
                esc_pos = 1;
                return;
            end
            if (b == "\"") begin
                f = frame_flags[depth];
                add_event(VT_STRING, f[6], 1'b1, f[3], 8'h00, 1'b0);
                if (f[3]) frame_flags[depth] = F_COLON;
                else close_value();
                return;
            end
            if (!b[7]) begin
                add_text(b);
                return;
            end
            if ((b & 8'hE0) == 8'hC0) utf8_left = 1;
            else if ((b & 8'hF0) == 8'hE0) utf8_left = 2;
            else if ((b & 8'hF8) == 8'hF0) utf8_left = 3;
            else begin
                add_error();
                return;
            end
            add_text(b);
            return;
        end
        if (esc_pos == 1) begin
            case (b)
                "\"", "\\", "/": c = b;
                "b": c = 8'h08;
                "f": c = 8'h0C;
                "n": c = 8'h0A;
                "r": c = 8'h0D;
                "t": c = 8'h09;
                "u": begin
                    esc_pos = 2;
                    hex_acc = '0;
                    return;
                end
                default: begin
                    add_error();
                    return;
                end
            endcase
            esc_pos = 0;
            add_text(c);
            return;
        end
        h = hex_digit(b);
        if (h < 0) begin
            add_error();
            return;
        end
        hex_acc = {hex_acc[11:0], 4'(h)};
        if (esc_pos < 5) begin
            esc_pos++;
            return;
        end
        esc_pos = 0;
        if (hex_acc < 16'd128) begin
            add_text(hex_acc[7:0]);
        end else if (hex_acc < 16'd2048) begin
            add_text(8'hC0 | 8'(hex_acc >> 6));
            add_text(8'h80 | 8'(hex_acc & 16'h3F));
        end else begin
            add_text(8'hE0 | 8'(hex_acc >> 12));
            add_text(8'h80 | 8'((hex_acc >> 6) & 16'h3F));
            add_text(8'h80 | 8'(hex_acc & 16'h3F));
        end
    endfunction

    function automatic void literal_byte(logic [2:0] kind, logic [7:0] b);
        string word;
        word = (kind == K_TRUE) ? "true" : (kind == K_FALSE) ? "false" : "null";
        if (esc_pos >= word.len() || b != word[esc_pos]) begin
            add_error();
            return;
        end
        esc_pos++;
        if (esc_pos == word.len()) begin
            esc_pos = 0;
            add_event((kind == K_TRUE) ? VT_TRUE : (kind == K_FALSE) ? VT_FALSE : VT_NULL,
                      1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
            close_value();
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        logic [2:0] kind;
        byte_events.delete();
        if (stuck) return;
        kind = frame_flags[depth][2:0];
        if (kind == K_STR) begin
            string_byte(b);
        end else if (kind == K_NUM) begin
            if (number_char(b)) begin
                if (num_len >= NUMBER_TEXT_MAX) begin
                    add_error();
                end else begin
                    add_event(VT_NUMBER, 1'b0, 1'b0, 1'b0, b, 1'b1);
                    num_len++;
                end
            end else begin
                add_event(VT_NUMBER, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
                close_value();
                num_len = 0;
                plain_byte(b);
            end
        end else if (kind >= K_TRUE) begin
            literal_byte(kind, b);
        end else begin
            plain_byte(b);
        end
        if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
        foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
    endfunction

    always @(posedge i_clk) begin
        t_evt got;
        t_evt want;
        if (!i_rst_n) begin
            clear_tokenizer();
            expected_events.delete();
            o_fail_count  <= 0;
            o_event_count <= 0;
        end else begin
            if (i_evt.valid && i_evt.ready) begin
                got.value_type    = i_evt.value_type;
                got.is_start      = i_evt.is_start;
                got.is_end        = i_evt.is_end;
                got.is_key        = i_evt.is_key;
                got.nest_level    = i_evt.nest_level;
                got.element_index = i_evt.element_index;
                got.data_byte     = i_evt.data_byte;
                got.data_valid    = i_evt.data_valid;
                got.last          = i_evt.last;
                o_event_count <= o_event_count + 1;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        $display("%0t: event mismatch, expected %p, actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) tokenize_byte(i_in.in_byte);
        end
        o_pending = expected_events.size();
    end

endmodule

### tb/tb_streaming_json_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Streaming JSON tokenizer testbench
// Feeds directed and randomly generated JSON text, including deep nesting,
// escapes, UTF-8, long numbers and a stretch of back-to-back traffic, ending
// in one syntax fault, with random idling on both sides and a checker beside
// the block.
// ----------------------------------------------------------------------------
module tb_streaming_json_tokenizer_top;
    import jtok_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   event_count;
    int   bytes_sent;
    bit   steady;
    int   hold_req;
    int   hold_seen;
    int   hold_left;
    int   cycles;
    logic [7:0] text_q[$];

    jtok_in_if  in_ch();
    jtok_evt_if evt_ch();

    streaming_json_tokenizer_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_evt  (evt_ch.source)
    );

    tb_jtok_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_evt        (evt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_event_count(event_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        evt_ch.ready = 1'b0;
        hold_seen    = 0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= steady || ($urandom_range(99) >= 38);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void add_space();
        string ws;
        ws = " \n\r\t";
        if ($urandom_range(3) == 0) text_q.push_back(ws[$urandom_range(3)]);
    endfunction

    function automatic void add_hex(logic [15:0] v);
        string lo;
        string hi;
        lo = "0123456789abcdef";
        hi = "0123456789ABCDEF";
        for (int i = 3; i >= 0; i--) begin
            if ($urandom_range(1)) text_q.push_back(lo[v[i*4 +: 4]]);
            else text_q.push_back(hi[v[i*4 +: 4]]);
        end
    endfunction

    function automatic void add_string();
        string esc;
        logic [7:0] c;
        int n;
        esc = "\"\\/bfnrt";
        n   = $urandom_range(0, 6);
        text_q.push_back("\"");
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == "\"" || c == "\\") c = "a";
                    text_q.push_back(c);
                end
                3: text_q.push_back(8'($urandom_range(0, 8'h1F)));
                4: begin
                    text_q.push_back("\\");
                    text_q.push_back(esc[$urandom_range(esc.len() - 1)]);
                end
                5: begin
                    add_str("\\u");
                    case ($urandom_range(2))
                        0: add_hex(16'($urandom_range(0, 127)));
                        1: add_hex(16'($urandom_range(128, 2047)));
                        default: add_hex(16'($urandom_range(2048, 65535)));
                    endcase
                end
                6: begin
                    text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                7: begin
                    text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                8: begin
                    text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                    repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                default: text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
            endcase
        end
        text_q.push_back("\"");
    endfunction

    function automatic void add_number();
        string chars;
        chars = "0123456789.+-Ee";
        text_q.push_back($urandom_range(3) == 0 ? 8'("-") : 8'($urandom_range("0", "9")));
        repeat ($urandom_range(0, 8)) text_q.push_back(chars[$urandom_range(chars.len() - 1)]);
    endfunction

    function automatic void add_value(int lvl);
        int n;
        int pick;
        pick = (lvl < $urandom_range(1, 4)) ? $urandom_range(0, 6) : $urandom_range(2, 6);
        case (pick)
            0: begin
                text_q.push_back("{");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) text_q.push_back(",");
                    add_space();
                    add_string();
                    add_space();
                    text_q.push_back(":");
                    add_space();
                    add_value(lvl + 1);
                    add_space();
                end
                text_q.push_back("}");
            end
            1: begin
                text_q.push_back("[");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) text_q.push_back(",");
                    add_space();
                    add_value(lvl + 1);
                    add_space();
                end
                text_q.push_back("]");
            end
            2, 3: add_string();
            4: add_number();
            default: begin
                case ($urandom_range(2))
                    0: add_str("true");
                    1: add_str("false");
                    default: add_str("null");
                endcase
            end
        endcase
    endfunction

    task automatic send_text();
        while (text_q.size() > 0) begin
            while (!steady && $urandom_range(99) < 38) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.in_byte <= text_q.pop_front();
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            bytes_sent++;
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        string sep;
        sep           = " \n\r\t,";
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        steady        = 1'b0;
        hold_req      = 0;
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_str("{}[]\"\" {\"k\":\"v\",\"n\":-1.5e+3,\"a\":[true,false,null,[],{}]}");
        add_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0041\\u00e9\\u20ACx\"");
        text_q.push_back("\"");
        text_q.push_back(8'hC3);
        text_q.push_back(8'hA9);
        text_q.push_back(8'hF0);
        repeat (3) text_q.push_back(8'hBF);
        text_q.push_back("\"");
        text_q.push_back(" ");
        repeat (NUMBER_TEXT_MAX) text_q.push_back("9");
        text_q.push_back(",");
        repeat (STACK_DEPTH - 1) text_q.push_back("[");
        repeat (STACK_DEPTH - 1) text_q.push_back("]");
        hold_req <= 1;
        send_text();

        while (bytes_sent < 300) begin
            add_value(0);
            text_q.push_back(sep[$urandom_range(sep.len() - 1)]);
            send_text();
            if ($urandom_range(7) == 0) begin
                @(posedge i_clk);
                wait (pending == 0);
            end
        end
        @(posedge i_clk);
        wait (pending == 0);

        steady <= 1'b1;
        while (bytes_sent < 360) begin
            add_value(0);
            text_q.push_back(sep[$urandom_range(sep.len() - 1)]);
            send_text();
        end
        @(posedge i_clk);
        wait (pending == 0);
        steady <= 1'b0;

        case ($urandom_range(0, 7))
            0: add_str("[1,]");
            1: add_str("{\"a\"}");
            2: repeat (STACK_DEPTH) text_q.push_back("[");
            3: repeat (NUMBER_TEXT_MAX + 1) text_q.push_back("1");
            4: add_str("\"\\x\"");
            5: begin
                text_q.push_back("\"");
                text_q.push_back(8'hC3);
                text_q.push_back("A");
            end
            6: add_str("tru3");
            default: text_q.push_back(8'hFF);
        endcase
        repeat (20) text_q.push_back(8'($urandom_range(0, 255)));
        send_text();

        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d text bytes (nesting, escapes, UTF-8, literals, numbers,", bytes_sent);
        $display("a back-to-back stretch, one closing syntax fault); checked %0d events.",
                 event_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/jtok_pkg.sv
sv/jtok_in_if.sv
sv/jtok_evt_if.sv
sv/jtok_ram.sv
sv/streaming_json_tokenizer_top.sv
tb/tb_jtok_checker.sv
tb/tb_streaming_json_tokenizer_top.sv
